// ===== rtl/core/cpr_pkg.sv =====
// Shared types and constants for the clock page replacer.
// Holds the item structs, the control state enum and the cell command types.
// No dependencies.
package cpr_pkg;

    localparam int PAGE_NUM_BITS = 20;
    localparam int WS_DEPTH_DEF  = 32;
    localparam int SLOT_FIELD_W  = 5;
    localparam int WS_SIZE_W     = 6;
    localparam int CFG_IDX_W     = 1;

    localparam logic [WS_SIZE_W-1:0] WS_SIZE_RESET = 6'd32;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WS_SIZE = 1'b1;

    localparam logic [1:0] STAT_HIT      = 2'd0;
    localparam logic [1:0] STAT_PLACED   = 2'd1;
    localparam logic [1:0] STAT_REPLACED = 2'd2;
    localparam logic [1:0] STAT_REJECT   = 2'd3;

    typedef struct packed {
        logic [PAGE_NUM_BITS-1:0] page_number;
        logic                     is_write;
        logic                     placement_allowed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_FIELD_W-1:0]  slot_index;
        logic [PAGE_NUM_BITS-1:0] victim_page;
        logic                     write_back;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INJECT,
        OP_ADVANCE,
        OP_TOUCH,
        OP_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic                     clear_used;
        logic [PAGE_NUM_BITS-1:0] page;
        logic                     is_write;
    } cell_cmd_t;

    typedef struct packed {
        logic                     valid;
        logic                     hit;
        logic                     used;
        logic                     modified;
        logic [PAGE_NUM_BITS-1:0] page;
    } cell_rsp_t;

endpackage

// ===== rtl/core/clock_page_replacer_unit.sv =====
// A hit at slot k ends the lookup walk at that slot; a miss scans all S active slots, and a
// full set adds a clock sweep.
// One item at a time; the next item is taken in the cycle after the result is loaded.
// The token walk along the cell row sets how long each item takes.
// Reset clears all valid, used and modified bits, puts the hand at slot 0, selects plain clock
// and sets the working set size to 32. Top level; depends on cpr_pkg, cpr_cell and cpr_ctrl.
module clock_page_replacer_unit #(
    parameter int WS_DEPTH = cpr_pkg::WS_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cpr_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cpr_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpr_pkg::WS_SIZE_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(WS_DEPTH);
    localparam int CNT_W = $clog2(WS_DEPTH+1);

    logic policy_mode_reg, policy_mode_next;
    logic [cpr_pkg::WS_SIZE_W-1:0] ws_max_size_reg, ws_max_size_next;

    cpr_pkg::cell_cmd_t cmd;
    logic [IDX_W-1:0] cmd_idx;
    logic [CNT_W-1:0] size;
    cpr_pkg::cell_rsp_t rsp_arr [WS_DEPTH];
    cpr_pkg::cell_rsp_t rsp_or;
    logic [WS_DEPTH-1:0] tok_in;
    logic [WS_DEPTH-1:0] tok_fwd;
    logic [WS_DEPTH-1:0] tok_wrap;
    logic [WS_DEPTH-1:0] tok_vec;

    always_comb
    begin
        policy_mode_next = policy_mode_reg;
        ws_max_size_next = ws_max_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cpr_pkg::REG_POLICY:  policy_mode_next = cfg_wdata[0];
                cpr_pkg::REG_WS_SIZE: ws_max_size_next = cfg_wdata;
                default:              policy_mode_next = policy_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= 1'b0;
            ws_max_size_reg <= cpr_pkg::WS_SIZE_RESET;
        end
        else
        begin
            policy_mode_reg <= policy_mode_next;
            ws_max_size_reg <= ws_max_size_next;
        end
    end

    cpr_ctrl #(
        .WS_DEPTH (WS_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .policy_mode (policy_mode_reg),
        .ws_max_size (ws_max_size_reg),
        .rsp         (rsp_or),
        .cmd         (cmd),
        .cmd_idx     (cmd_idx),
        .size        (size)
    );

    assign tok_in[0] = |tok_wrap;

    genvar gi;
    generate
        for (gi = 0; gi < WS_DEPTH; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign tok_in[gi] = tok_fwd[gi-1];
            end
            cpr_cell #(
                .WS_DEPTH (WS_DEPTH),
                .CELL_IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .cmd_idx  (cmd_idx),
                .size     (size),
                .tok_in   (tok_in[gi]),
                .tok_fwd  (tok_fwd[gi]),
                .tok_wrap (tok_wrap[gi]),
                .rsp      (rsp_arr[gi])
            );
        end
    endgenerate

    assign tok_vec = tok_fwd | tok_wrap;

    always_comb
    begin
        rsp_or = '0;
        for (int i = 0; i < WS_DEPTH; i++)
        begin
            rsp_or = rsp_or | rsp_arr[i];
        end
    end

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the scan token");

endmodule

// ===== rtl/core/cpr_cell.sv =====
// One working set slot: page, valid, used and modified bits plus the scan token.
// The token moves to the neighbor cell on an advance command and wraps at the active size.
// Depends on cpr_pkg.
module cpr_cell #(
    parameter int WS_DEPTH = cpr_pkg::WS_DEPTH_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cpr_pkg::cell_cmd_t              cmd,
    input  logic [$clog2(WS_DEPTH)-1:0]     cmd_idx,
    input  logic [$clog2(WS_DEPTH+1)-1:0]   size,
    input  logic                            tok_in,
    output logic                            tok_fwd,
    output logic                            tok_wrap,
    output cpr_pkg::cell_rsp_t              rsp
);

    localparam int IDX_W = $clog2(WS_DEPTH);
    localparam int CNT_W = $clog2(WS_DEPTH+1);

    logic [cpr_pkg::PAGE_NUM_BITS-1:0] page_reg, page_next;
    logic valid_reg, valid_next;
    logic used_reg, used_next;
    logic mod_reg, mod_next;
    logic tok_reg, tok_next;
    logic sel;
    logic last;

    assign sel  = (cmd_idx == IDX_W'(CELL_IDX));
    assign last = ((CNT_W'(CELL_IDX) + CNT_W'(1)) == size);

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        used_next  = used_reg;
        mod_next   = mod_reg;
        tok_next   = 1'b0;
        case (cmd.op)
            cpr_pkg::OP_INJECT:
            begin
                tok_next = sel;
            end
            cpr_pkg::OP_ADVANCE:
            begin
                tok_next = tok_in;
                if (tok_reg && cmd.clear_used)
                begin
                    used_next = 1'b0;
                end
            end
            cpr_pkg::OP_TOUCH:
            begin
                if (sel)
                begin
                    used_next = 1'b1;
                    mod_next  = mod_reg | cmd.is_write;
                end
            end
            cpr_pkg::OP_LOAD:
            begin
                if (sel)
                begin
                    page_next  = cmd.page;
                    valid_next = 1'b1;
                    used_next  = 1'b1;
                    mod_next   = cmd.is_write;
                end
            end
            default:
            begin
                tok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
            mod_reg   <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            mod_reg   <= mod_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign tok_fwd  = tok_reg & ~last;
    assign tok_wrap = tok_reg & last;

    always_comb
    begin
        rsp = '0;
        if (tok_reg)
        begin
            rsp.valid    = valid_reg;
            rsp.hit      = valid_reg && (page_reg == cmd.page);
            rsp.used     = used_reg;
            rsp.modified = mod_reg;
            rsp.page     = page_reg;
        end
    end

endmodule

// ===== rtl/core/cpr_ctrl.sv =====
// Sequencer for the clock page replacer: lookup walk, clock sweep, slot update and result.
// Drives the cell row through one command struct and reads the token holder's response.
// Depends on cpr_pkg.
module cpr_ctrl #(
    parameter int WS_DEPTH = cpr_pkg::WS_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cpr_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cpr_pkg::out_item_t              out_item,
    input  logic                            policy_mode,
    input  logic [cpr_pkg::WS_SIZE_W-1:0]   ws_max_size,
    input  cpr_pkg::cell_rsp_t              rsp,
    output cpr_pkg::cell_cmd_t              cmd,
    output logic [$clog2(WS_DEPTH)-1:0]     cmd_idx,
    output logic [$clog2(WS_DEPTH+1)-1:0]   size
);

    localparam int IDX_W = $clog2(WS_DEPTH);
    localparam int CNT_W = $clog2(WS_DEPTH+1);
    localparam int SZ_W  = (CNT_W > cpr_pkg::WS_SIZE_W) ? CNT_W : cpr_pkg::WS_SIZE_W;

    cpr_pkg::state_t state_reg, state_next;
    cpr_pkg::in_item_t ref_reg, ref_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [1:0] pass_reg, pass_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [1:0] status_reg, status_next;
    logic [cpr_pkg::PAGE_NUM_BITS-1:0] victim_reg, victim_next;
    logic wb_reg, wb_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic out_valid_reg, out_valid_next;
    cpr_pkg::out_item_t out_item_reg, out_item_next;

    logic [SZ_W-1:0] ws_ext;
    logic [CNT_W-1:0] active_size;
    logic [CNT_W-1:0] pos_plus;
    logic [IDX_W-1:0] pos_wrap;
    logic [IDX_W-1:0] hand_start;
    logic at_end;
    logic n_end;
    logic accept;
    logic out_load;
    logic lookup_free;
    logic sweep_victim;

    assign ws_ext = SZ_W'(ws_max_size);

    always_comb
    begin
        if (ws_ext == '0)
        begin
            active_size = CNT_W'(1);
        end
        else if (ws_ext > SZ_W'(WS_DEPTH))
        begin
            active_size = CNT_W'(WS_DEPTH);
        end
        else
        begin
            active_size = CNT_W'(ws_ext);
        end
    end

    assign pos_plus   = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_wrap   = (pos_plus >= s_reg) ? '0 : IDX_W'(pos_plus);
    assign at_end     = (pos_plus == s_reg);
    assign n_end      = ((CNT_W'(n_reg) + CNT_W'(1)) == s_reg);
    assign hand_start = (CNT_W'(hand_reg) < s_reg) ? hand_reg : '0;
    assign accept     = in_valid && in_ready;
    assign out_load   = (state_reg == cpr_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign lookup_free = free_found_reg || !rsp.valid;

    always_comb
    begin
        if (policy_mode == 1'b0)
        begin
            sweep_victim = !rsp.used;
        end
        else if (pass_reg[0] == 1'b0)
        begin
            sweep_victim = !rsp.used && !rsp.modified;
        end
        else
        begin
            sweep_victim = !rsp.used && rsp.modified;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cpr_pkg::ST_LOOKUP;
                end
            end
            cpr_pkg::ST_LOOKUP:
            begin
                if (rsp.hit)
                begin
                    state_next = cpr_pkg::ST_UPDATE;
                end
                else if (at_end)
                begin
                    if (!ref_reg.placement_allowed)
                    begin
                        state_next = cpr_pkg::ST_DONE;
                    end
                    else if (lookup_free)
                    begin
                        state_next = cpr_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = cpr_pkg::ST_SWEEP;
                    end
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                if (sweep_victim)
                begin
                    state_next = cpr_pkg::ST_UPDATE;
                end
            end
            cpr_pkg::ST_UPDATE:
            begin
                state_next = cpr_pkg::ST_DONE;
            end
            cpr_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ref_next        = ref_reg;
        s_next          = s_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        pass_next       = pass_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        victim_next     = victim_reg;
        wb_next         = wb_reg;
        hand_next       = hand_reg;
        in_ready        = 1'b0;
        cmd.op          = cpr_pkg::OP_NOP;
        cmd.clear_used  = 1'b0;
        cmd.page        = ref_reg.page_number;
        cmd.is_write    = ref_reg.is_write;
        cmd_idx         = '0;
        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    ref_next        = in_item;
                    s_next          = active_size;
                    pos_next        = '0;
                    free_found_next = 1'b0;
                    victim_next     = '0;
                    wb_next         = 1'b0;
                    cmd.op          = cpr_pkg::OP_INJECT;
                    cmd_idx         = '0;
                end
            end
            cpr_pkg::ST_LOOKUP:
            begin
                if (rsp.hit)
                begin
                    slot_next   = pos_reg;
                    status_next = cpr_pkg::STAT_HIT;
                end
                else
                begin
                    if (!rsp.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pos_reg;
                    end
                    if (at_end)
                    begin
                        if (!ref_reg.placement_allowed)
                        begin
                            status_next = cpr_pkg::STAT_REJECT;
                            slot_next   = '0;
                        end
                        else if (lookup_free)
                        begin
                            status_next = cpr_pkg::STAT_PLACED;
                            slot_next   = free_found_reg ? free_idx_reg : pos_reg;
                        end
                        else
                        begin
                            cmd.op    = cpr_pkg::OP_INJECT;
                            cmd_idx   = hand_start;
                            pos_next  = hand_start;
                            n_next    = '0;
                            pass_next = '0;
                        end
                    end
                    else
                    begin
                        cmd.op   = cpr_pkg::OP_ADVANCE;
                        pos_next = pos_wrap;
                    end
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                if (sweep_victim)
                begin
                    slot_next   = pos_reg;
                    status_next = cpr_pkg::STAT_REPLACED;
                    victim_next = rsp.page;
                    wb_next     = rsp.modified;
                    hand_next   = pos_wrap;
                end
                else
                begin
                    cmd.op         = cpr_pkg::OP_ADVANCE;
                    cmd.clear_used = !policy_mode || pass_reg[0];
                    pos_next       = pos_wrap;
                    if (n_end)
                    begin
                        n_next    = '0;
                        pass_next = pass_reg + 2'd1;
                    end
                    else
                    begin
                        n_next = n_reg + IDX_W'(1);
                    end
                end
            end
            cpr_pkg::ST_UPDATE:
            begin
                cmd.op  = (status_reg == cpr_pkg::STAT_HIT) ? cpr_pkg::OP_TOUCH : cpr_pkg::OP_LOAD;
                cmd_idx = slot_reg;
            end
            cpr_pkg::ST_DONE:
            begin
                cmd.op = cpr_pkg::OP_NOP;
            end
            default:
            begin
                cmd.op = cpr_pkg::OP_NOP;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_load)
        begin
            out_valid_next           = 1'b1;
            out_item_next.status     = status_reg;
            out_item_next.slot_index = cpr_pkg::SLOT_FIELD_W'(slot_reg);
            out_item_next.victim_page = victim_reg;
            out_item_next.write_back = wb_reg;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg        <= ref_next;
        s_reg          <= s_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        pass_reg       <= pass_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        victim_reg     <= victim_next;
        wb_reg         <= wb_next;
        out_item_reg   <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign size      = s_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpr_pkg::ST_LOOKUP || state_reg == cpr_pkg::ST_SWEEP)
        |-> (CNT_W'(pos_reg) < s_reg))
        else $error("scan position beyond active size");

    a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpr_pkg::ST_SWEEP && pass_reg == 2'd3) |-> sweep_victim)
        else $error("clock sweep ran past its last pass");

    a_victim_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status != cpr_pkg::STAT_REPLACED)
        |-> (!out_item_reg.write_back && out_item_reg.victim_page == '0))
        else $error("victim fields set without a replacement");

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpr_pkg::ST_UPDATE && status_reg == cpr_pkg::STAT_REPLACED)
        |=> (CNT_W'(hand_reg) < s_reg))
        else $error("clock hand left outside the active size");

endmodule

// ===== tb/clock_page_replacer_unit_tb.sv =====
// Testbench for clock_page_replacer_unit: a directed table, then random page references in
// phases of register settings and idling, each result checked against a typed row result or
// an in-file predictor. Depends on cpr_pkg and clock_page_replacer_unit.
module clock_page_replacer_unit_tb;

    localparam int SLOTS        = cpr_pkg::WS_DEPTH_DEF;
    localparam int PAGE_W       = cpr_pkg::PAGE_NUM_BITS;
    localparam int SIZE_W       = cpr_pkg::WS_SIZE_W;
    localparam int SLOT_W       = cpr_pkg::SLOT_FIELD_W;
    localparam int IDX_W        = cpr_pkg::CFG_IDX_W;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_DEPTH   = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 56;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 160;
    localparam int DIR_ROWS     = 26;

    localparam logic POLICY_CLOCK    = 1'b0;
    localparam logic POLICY_MODIFIED = 1'b1;

    typedef enum logic {ROW_CFG, ROW_REF} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [IDX_W-1:0]       reg_idx;
        logic [SIZE_W-1:0]      reg_val;
        cpr_pkg::in_item_t      item;
        logic                   typed;
        cpr_pkg::out_item_t     result;
    } dir_row_t;

    localparam cpr_pkg::in_item_t  NO_ITEM   = '0;
    localparam cpr_pkg::out_item_t NO_RESULT = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    cpr_pkg::in_item_t     in_item;
    logic                  out_valid;
    logic                  out_ready;
    cpr_pkg::out_item_t    out_item;
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [SIZE_W-1:0]     cfg_wdata;

    logic [PAGE_W-1:0]        slot_page [SLOTS];
    logic                     slot_valid [SLOTS];
    logic                     slot_used [SLOTS];
    logic                     slot_modified [SLOTS];
    int                       clock_hand;
    logic                     policy_sel;
    logic [SIZE_W-1:0]        ws_size_reg;
    cpr_pkg::out_item_t       expected_outcomes [$];

    int gap_pct;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int mismatch_count;
    int items_sent;
    int reg_writes;
    int hit_count;
    int placed_count;
    int replaced_count;
    int writeback_count;
    int reject_count;

    logic [PAGE_W-1:0] page_pool [POOL_DEPTH];

    logic phase_policy [PHASES] = '{POLICY_CLOCK, POLICY_MODIFIED, POLICY_CLOCK,
                                    POLICY_MODIFIED, POLICY_MODIFIED, POLICY_CLOCK,
                                    POLICY_MODIFIED, POLICY_CLOCK};
    int   phase_size  [PHASES] = '{4, 4, 8, 0, 32, 1, 6, 63};
    int   phase_gap   [PHASES] = '{0, 58, 0, 29, 0, 58, 0, 29};
    int   phase_stall [PHASES] = '{0, 0, 58, 29, 0, 0, 58, 29};
    logic phase_hold  [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'hFFFFF, 1'b0, 1'b0}, 1'b1,
          '{cpr_pkg::STAT_REJECT, 5'd0, 20'h0, 1'b0}},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'hFFFFF, 1'b1, 1'b1}, 1'b1,
          '{cpr_pkg::STAT_PLACED, 5'd0, 20'h0, 1'b0}},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00000, 1'b0, 1'b1}, 1'b1,
          '{cpr_pkg::STAT_PLACED, 5'd1, 20'h0, 1'b0}},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'hFFFFF, 1'b0, 1'b0}, 1'b1,
          '{cpr_pkg::STAT_HIT, 5'd0, 20'h0, 1'b0}},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00000, 1'b1, 1'b1}, 1'b1,
          '{cpr_pkg::STAT_HIT, 5'd1, 20'h0, 1'b0}},
        '{ROW_CFG, cpr_pkg::REG_WS_SIZE, 6'd2, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h12345, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'hABCDE, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00000, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_CFG, cpr_pkg::REG_WS_SIZE, 6'd0, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h54321, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h54321, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_CFG, cpr_pkg::REG_POLICY, 6'(POLICY_MODIFIED), NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_CFG, cpr_pkg::REG_WS_SIZE, 6'd3, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00000, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00002, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00003, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00004, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00005, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00003, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00006, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00007, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{ROW_CFG, cpr_pkg::REG_WS_SIZE, 6'd63, NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_CFG, cpr_pkg::REG_POLICY, 6'(POLICY_CLOCK), NO_ITEM, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h00008, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{ROW_REF, cpr_pkg::REG_POLICY, 6'd0, '{20'h0FFFF, 1'b0, 1'b1}, 1'b0, NO_RESULT}
    };

    clock_page_replacer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cpr_pkg::out_item_t resolve_reference(input cpr_pkg::in_item_t req);
        int                 span;
        int                 h;
        int                 k;
        int                 sweep;
        int                 slot;
        logic               found;
        cpr_pkg::out_item_t res;
        res = '0;
        span = (ws_size_reg == '0) ? 1 :
               ((int'(ws_size_reg) > SLOTS) ? SLOTS : int'(ws_size_reg));
        found = 1'b0;
        slot = 0;
        for (k = 0; k < span; k++)
        begin
            if (!found && slot_valid[k] && slot_page[k] == req.page_number)
            begin
                found = 1'b1;
                slot = k;
            end
        end
        if (found)
        begin
            res.status = cpr_pkg::STAT_HIT;
            res.slot_index = SLOT_W'(slot);
            slot_used[slot] = 1'b1;
            if (req.is_write)
                slot_modified[slot] = 1'b1;
        end
        else if (!req.placement_allowed)
        begin
            res.status = cpr_pkg::STAT_REJECT;
        end
        else
        begin
            for (k = 0; k < span; k++)
            begin
                if (!found && !slot_valid[k])
                begin
                    found = 1'b1;
                    slot = k;
                end
            end
            if (found)
            begin
                res.status = cpr_pkg::STAT_PLACED;
                slot_valid[slot] = 1'b1;
            end
            else
            begin
                h = (clock_hand < span) ? clock_hand : 0;
                if (policy_sel == POLICY_CLOCK)
                begin
                    for (k = 0; k <= span; k++)
                    begin
                        if (!found)
                        begin
                            if (!slot_used[h])
                                found = 1'b1;
                            else
                            begin
                                slot_used[h] = 1'b0;
                                h = (h + 1 >= span) ? 0 : h + 1;
                            end
                        end
                    end
                end
                else
                begin
                    for (sweep = 0; sweep < 4; sweep++)
                    begin
                        for (k = 0; k < span; k++)
                        begin
                            if (!found)
                            begin
                                if (sweep % 2 == 0)
                                begin
                                    if (!slot_used[h] && !slot_modified[h])
                                        found = 1'b1;
                                end
                                else if (!slot_used[h] && slot_modified[h])
                                    found = 1'b1;
                                else
                                    slot_used[h] = 1'b0;
                                if (!found)
                                    h = (h + 1 >= span) ? 0 : h + 1;
                            end
                        end
                    end
                end
                slot = h;
                res.status = cpr_pkg::STAT_REPLACED;
                res.victim_page = slot_page[slot];
                res.write_back = slot_modified[slot];
                clock_hand = (slot + 1 >= span) ? 0 : slot + 1;
            end
            res.slot_index = SLOT_W'(slot);
            slot_page[slot] = req.page_number;
            slot_used[slot] = 1'b1;
            slot_modified[slot] = req.is_write;
        end
        return res;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == cpr_pkg::REG_POLICY)
            policy_sel = val[0];
        else
            ws_size_reg = val;
        reg_writes++;
    endtask

    task automatic offer_reference(input cpr_pkg::in_item_t req, input logic typed,
                                   input cpr_pkg::out_item_t typed_result);
        cpr_pkg::out_item_t outcome;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        outcome = resolve_reference(req);
        expected_outcomes.push_back(typed ? typed_result : outcome);
        items_sent++;
    endtask

    initial
    begin
        int                 hold_left;
        cpr_pkg::out_item_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                case (out_item.status)
                    cpr_pkg::STAT_HIT:      hit_count++;
                    cpr_pkg::STAT_PLACED:   placed_count++;
                    cpr_pkg::STAT_REPLACED: replaced_count++;
                    default:                reject_count++;
                endcase
                if (out_item.write_back)
                    writeback_count++;
                if (expected_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Result with no item pending: status %0d slot %0d victim %05h",
                                 out_item.status, out_item.slot_index, out_item.victim_page);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (out_item.status !== want.status ||
                        out_item.slot_index !== want.slot_index ||
                        out_item.victim_page !== want.victim_page ||
                        out_item.write_back !== want.write_back)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"Mismatch: expected status %0d slot %0d victim %05h wb %0d,",
                                      " got status %0d slot %0d victim %05h wb %0d"},
                                     want.status, want.slot_index, want.victim_page,
                                     want.write_back, out_item.status, out_item.slot_index,
                                     out_item.victim_page, out_item.write_back);
                    end
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int                r;
        int                p;
        int                n;
        int                k;
        int                span;
        cpr_pkg::in_item_t req;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        mismatch_count = 0;
        items_sent = 0;
        reg_writes = 0;
        hit_count = 0;
        placed_count = 0;
        replaced_count = 0;
        writeback_count = 0;
        reject_count = 0;
        for (k = 0; k < SLOTS; k++)
        begin
            slot_page[k] = '0;
            slot_valid[k] = 1'b0;
            slot_used[k] = 1'b0;
            slot_modified[k] = 1'b0;
        end
        for (k = 0; k < POOL_DEPTH; k++)
            page_pool[k] = PAGE_W'($urandom);
        clock_hand = 0;
        policy_sel = POLICY_CLOCK;
        ws_size_reg = cpr_pkg::WS_SIZE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            else
                offer_reference(directed_rows[r].item, directed_rows[r].typed,
                                directed_rows[r].result);
        end

        for (p = 0; p < PHASES; p++)
        begin
            write_reg(cpr_pkg::REG_POLICY, SIZE_W'(phase_policy[p]));
            write_reg(cpr_pkg::REG_WS_SIZE, SIZE_W'(phase_size[p]));
            gap_pct = phase_gap[p];
            stall_pct = phase_stall[p];
            if (phase_hold[p])
                hold_requests++;
            span = (phase_size[p] < 1) ? 1 : ((phase_size[p] > SLOTS) ? SLOTS : phase_size[p]);
            span = (span + 3 > POOL_DEPTH) ? POOL_DEPTH : span + 3;
            for (k = 0; k < POOL_DEPTH; k++)
            begin
                if ($urandom_range(1) == 1)
                    page_pool[k] = PAGE_W'($urandom);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 85)
                    req.page_number = page_pool[$urandom_range(span - 1)];
                else
                    req.page_number = PAGE_W'($urandom);
                req.is_write = 1'($urandom_range(1));
                req.placement_allowed = ($urandom_range(99) < 85);
                offer_reference(req, 1'b0, NO_RESULT);
            end
        end

        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d page references and %0d register writes over %0d phases.",
                 items_sent, reg_writes, PHASES);
        $display({"Outcomes: %0d hits, %0d placements, %0d replacements",
                  " (%0d write-backs), %0d rejects."},
                 hit_count, placed_count, replaced_count, writeback_count, reject_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_cell.sv
rtl/core/cpr_ctrl.sv
rtl/core/clock_page_replacer_unit.sv
tb/clock_page_replacer_unit_tb.sv
